[rtl/mlpc_pkg.sv]
// Shared constants, types and the sigmoid lookup table of the perceptron classifier.
package mlpc_pkg;

  // Record shape and network size.
  localparam int FEATURE_CNT = 6;
  localparam int HIDDEN_CNT  = 2;
  localparam int FEAT_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int LEVEL_W    = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_WEIGHTS_W = HIDDEN_CNT * WEIGHT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIDDEN_A = 2'd0,
    CFG_HIDDEN_B = 2'd1,
    CFG_HIDDEN_C = 2'd2,
    CFG_OUTPUT   = 2'd3
  } cfg_idx_t;

  // Sigmoid table geometry.
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

  typedef logic [SIG_ENTRIES-1:0][LEVEL_W-1:0] sig_tab_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // One table entry: sigmoid at the bin midpoint, rounded to Q0.16.
  function automatic logic [LEVEL_W-1:0] sig_entry(int unsigned k);
    longint      num;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y3;
    logic [63:0] y4;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] n;
    logic [63:0] rem;
    logic [63:0] q;
    num = longint'(2 * k + 1) * 64'sd8 - longint'(8 * SIG_ENTRIES);
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    a   = (mag << 30) / SIG_ENTRIES;
    y   = a >> 8;
    y2  = (y * y) >> 30;
    y3  = (y2 * y) >> 30;
    y4  = (y3 * y) >> 30;
    e   = Q30_ONE - y + y2 / 2 - y3 / 6 + y4 / 24;
    // Raise exp(-|x|/256) to the 256th power by repeated squaring.
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (Q30_ONE >> 1)) >> 30;
    end
    d = Q30_ONE + e;
    if (neg) begin
      n = (e << 16) + (d >> 1);
    end else begin
      n = (64'd1 << 46) + (d >> 1);
    end
    // Restoring long division, one quotient bit per step.
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[LEVEL_W-1:0];
  endfunction

  function automatic sig_tab_t sig_build();
    sig_tab_t t;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      t[k] = sig_entry(k);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

[rtl/mlpc_if.sv]
// Valid/ready channel interfaces for records, results and configuration writes.
interface mlpc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_0;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_1;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_2;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_3;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_4;
  logic signed [mlpc_pkg::FEAT_W-1:0]       feature_5;
  logic                                     target;

  modport source (output valid, feature_0, feature_1, feature_2, feature_3, feature_4,
                  feature_5, target, input ready);
  modport sink   (input valid, feature_0, feature_1, feature_2, feature_3, feature_4,
                  feature_5, target, output ready);
endinterface

interface mlpc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               prediction;
  logic                               matches_target;
  logic [mlpc_pkg::LEVEL_W-1:0]       output_level;

  modport source (output valid, prediction, matches_target, output_level, input ready);
  modport sink   (input valid, prediction, matches_target, output_level, output ready);
endinterface

interface mlpc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [mlpc_pkg::CFG_IDX_W-1:0]       index;
  logic [mlpc_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mlp_sigmoid_classifier_core.sv]
// Two-layer perceptron classifier with table sigmoid, one record per unstalled cycle.
//
// Usage: records enter on in_chan (six signed Q4.12 features and a target bit).
// For each request the block returns one result on out_chan: the prediction,
// whether it matches the target, and the Q0.16 sigmoid level of the output sum.
// Weights are loaded through cfg_chan (index 0..2: packed input-to-hidden
// weights, index 3: hidden-to-output weights); cfg_chan is always ready and
// should be written only while no request is in flight.
//
// Pipeline: eight register stages (feature capture, products, pair sums,
// hidden sums, hidden sigmoid, output products, output sum, result).
// A result is valid once its request has reached the result stage. Throughput is one
// request per cycle while out_chan is ready; the depth is set by the 16x16
// multipliers and the two table lookups, each given a stage of its own.
//
// Reset clears all stage valid bits and all weights to zero.
// When the receiver stalls, each stage holds only if the next one is full,
// so empty stages keep filling; in_chan.ready drops only when all eight
// stages hold requests.
module mlp_sigmoid_classifier_core (
  input  logic        clk,
  input  logic        rst_n,
  mlpc_in_if.sink     in_chan,
  mlpc_out_if.source  out_chan,
  mlpc_cfg_if.sink    cfg_chan
);

  localparam int NF       = mlpc_pkg::FEATURE_CNT;
  localparam int NH       = mlpc_pkg::HIDDEN_CNT;
  localparam int W_W      = mlpc_pkg::WEIGHT_W;
  localparam int L_W      = mlpc_pkg::LEVEL_W;
  localparam int IDX_W    = mlpc_pkg::SIG_IDX_W;
  localparam int STAGES   = 8;
  localparam int N_PAIRS  = (NF + 1) / 2;
  localparam int PROD_W   = 2 * mlpc_pkg::FEAT_W;
  localparam int PSUM_W   = PROD_W + 1;
  localparam int HSUM_W   = PROD_W + $clog2(NF) + 1;
  localparam int OPROD_W  = L_W + 1 + W_W;
  localparam int OSUM_W   = OPROD_W + $clog2(NH) + 1;
  localparam int H_FRAC   = 24;
  localparam int O_FRAC   = 28;
  localparam int HW_LANES = 12;

  localparam logic signed [HSUM_W-1:0] H_LIM = HSUM_W'(1) << (H_FRAC + 3);
  localparam logic signed [OSUM_W-1:0] O_LIM = OSUM_W'(1) << (O_FRAC + 3);

  // Configuration registers.
  logic [mlpc_pkg::CFG_DATA_W-1:0]    hw_a_r;
  logic [mlpc_pkg::CFG_DATA_W-1:0]    hw_b_r;
  logic [mlpc_pkg::CFG_DATA_W-1:0]    hw_c_r;
  logic [mlpc_pkg::OUT_WEIGHTS_W-1:0] ow_r;
  logic [HW_LANES*W_W-1:0]            hw_all;

  // Pipeline control.
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] adv;
  logic              in_acc;
  logic              out_acc;
  logic              tgt_r [STAGES-1];

  // Pipeline payload.
  logic signed [mlpc_pkg::FEAT_W-1:0] feat_r  [NF];
  logic signed [mlpc_pkg::FEAT_W-1:0] feat_in [NF];
  logic signed [PROD_W-1:0]  prod_r   [NH][NF];
  logic signed [PROD_W-1:0]  prod_nxt [NH][NF];
  logic signed [PSUM_W-1:0]  psum_r   [NH][N_PAIRS];
  logic signed [PSUM_W-1:0]  psum_nxt [NH][N_PAIRS];
  logic signed [HSUM_W-1:0]  hsum_r   [NH];
  logic signed [HSUM_W-1:0]  hsum_nxt [NH];
  logic [L_W-1:0]            act_r    [NH];
  logic [L_W-1:0]            act_nxt  [NH];
  logic signed [OPROD_W-1:0] oprod_r  [NH];
  logic signed [OPROD_W-1:0] oprod_nxt[NH];
  logic signed [OSUM_W-1:0]  osum_r;
  logic signed [OSUM_W-1:0]  osum_nxt;
  logic                      pred_r;
  logic                      match_r;
  logic [L_W-1:0]            level_r;
  logic [L_W-1:0]            level_nxt;
  logic signed [HSUM_W-1:0]  h_off    [NH];
  logic signed [OSUM_W-1:0]  o_off;
  logic                      pred_nxt;

  // Configuration writes are always taken.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_a_r <= '0;
      hw_b_r <= '0;
      hw_c_r <= '0;
      ow_r   <= '0;
    end else if (cfg_chan.valid) begin
      unique case (mlpc_pkg::cfg_idx_t'(cfg_chan.index))
        mlpc_pkg::CFG_HIDDEN_A: hw_a_r <= cfg_chan.data;
        mlpc_pkg::CFG_HIDDEN_B: hw_b_r <= cfg_chan.data;
        mlpc_pkg::CFG_HIDDEN_C: hw_c_r <= cfg_chan.data;
        mlpc_pkg::CFG_OUTPUT:   ow_r   <= cfg_chan.data[mlpc_pkg::OUT_WEIGHTS_W-1:0];
        default: ;
      endcase
    end
  end

  assign hw_all = {hw_c_r, hw_b_r, hw_a_r};

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_chan.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_chan.ready = adv[0];
  assign in_acc        = in_chan.valid && adv[0];
  assign out_acc       = vld_r[STAGES-1] && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Target bit rides along with its record.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tgt_r[0] <= in_chan.target;
    end
    for (int k = 1; k < STAGES - 1; k++) begin
      if (adv[k]) begin
        tgt_r[k] <= tgt_r[k-1];
      end
    end
  end

  // Stage 1: capture the features.
  assign feat_in[0] = in_chan.feature_0;
  assign feat_in[1] = in_chan.feature_1;
  assign feat_in[2] = in_chan.feature_2;
  assign feat_in[3] = in_chan.feature_3;
  assign feat_in[4] = in_chan.feature_4;
  assign feat_in[5] = in_chan.feature_5;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      feat_r <= feat_in;
    end
  end

  // Stage 2: one product per feature and hidden unit.
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      for (int f = 0; f < NF; f++) begin
        prod_nxt[h][f] = feat_r[f] * $signed(hw_all[(f * NH + h) * W_W +: W_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 3: add products in pairs.
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      for (int p = 0; p < N_PAIRS; p++) begin
        if (2 * p + 1 < NF) begin
          psum_nxt[h][p] = PSUM_W'(prod_r[h][2*p]) + PSUM_W'(prod_r[h][2*p+1]);
        end else begin
          psum_nxt[h][p] = PSUM_W'(prod_r[h][2*p]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      psum_r <= psum_nxt;
    end
  end

  // Stage 4: complete the hidden sums (Q12.24).
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      hsum_nxt[h] = '0;
      for (int p = 0; p < N_PAIRS; p++) begin
        hsum_nxt[h] = hsum_nxt[h] + HSUM_W'(psum_r[h][p]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      hsum_r <= hsum_nxt;
    end
  end

  // Stage 5: hidden sigmoid, saturating sums outside [-8,8).
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      h_off[h] = hsum_r[h] + H_LIM;
      if (hsum_r[h] < -H_LIM) begin
        act_nxt[h] = mlpc_pkg::SIG_TABLE[0];
      end else if (hsum_r[h] >= H_LIM) begin
        act_nxt[h] = mlpc_pkg::SIG_TABLE[mlpc_pkg::SIG_ENTRIES-1];
      end else begin
        act_nxt[h] = mlpc_pkg::SIG_TABLE[h_off[h][H_FRAC+3 -: IDX_W]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      act_r <= act_nxt;
    end
  end

  // Stage 6: weight each activation by its output weight.
  always_comb begin
    for (int h = 0; h < NH; h++) begin
      oprod_nxt[h] = $signed({1'b0, act_r[h]}) * $signed(ow_r[h * W_W +: W_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      oprod_r <= oprod_nxt;
    end
  end

  // Stage 7: output sum (Q.28).
  always_comb begin
    osum_nxt = '0;
    for (int h = 0; h < NH; h++) begin
      osum_nxt = osum_nxt + OSUM_W'(oprod_r[h]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      osum_r <= osum_nxt;
    end
  end

  // Stage 8: prediction, target compare and output level.
  always_comb begin
    o_off    = osum_r + O_LIM;
    pred_nxt = (osum_r > 0);
    if (osum_r < -O_LIM) begin
      level_nxt = mlpc_pkg::SIG_TABLE[0];
    end else if (osum_r >= O_LIM) begin
      level_nxt = mlpc_pkg::SIG_TABLE[mlpc_pkg::SIG_ENTRIES-1];
    end else begin
      level_nxt = mlpc_pkg::SIG_TABLE[o_off[O_FRAC+3 -: IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      pred_r  <= pred_nxt;
      match_r <= (pred_nxt == tgt_r[STAGES-2]);
      level_r <= level_nxt;
    end
  end

  assign out_chan.valid          = vld_r[STAGES-1];
  assign out_chan.prediction     = pred_r;
  assign out_chan.matches_target = match_r;
  assign out_chan.output_level   = level_r;

  // A positive output sum always lands in the upper half of the table.
  a_pred_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.prediction) |-> out_chan.output_level[L_W-1])
    else $error("prediction disagrees with output level");

  // Requests in flight change only by those accepted and delivered.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(vld_r) == $past($countones(vld_r))
                      + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline lost or invented a request");

  // Input back-pressure only when every stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&vld_r))
    else $error("input stalled with an empty stage");

endmodule
